[hdl/umepc_pkg.sv]
`timescale 1ns / 1ps

package umepc_pkg;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] header_byte;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [2:0] message_length;
   } req_item_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [1:0] out_length;
   } rsp_item_type;

   localparam logic [7:0] STATUS_MIN    = 8'h80;
   localparam logic [7:0] REALTIME_MIN  = 8'hF8;
   localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;
   localparam logic [3:0] PROGRAM_NIBBLE  = 4'hC;
   localparam logic [3:0] PRESSURE_NIBBLE = 4'hD;
   localparam logic [7:0] STATUS_MTC    = 8'hF1;
   localparam logic [7:0] STATUS_SPP    = 8'hF2;
   localparam logic [7:0] STATUS_SONG   = 8'hF3;
   localparam logic [7:0] STATUS_TUNE   = 8'hF6;

   localparam logic [3:0] CIN_TWO_BYTE   = 4'h2;
   localparam logic [3:0] CIN_THREE_BYTE = 4'h3;
   localparam logic [3:0] CIN_ONE_SYS    = 4'h5;
   localparam logic [3:0] CIN_SINGLE     = 4'hF;

   localparam logic [2:0] MAX_LENGTH = 3'd3;

   function automatic logic [1:0] cin_length(input logic [3:0] cin);
      logic [1:0] n;
      case (cin)
         4'h0, 4'h1:                      n = 2'd0;
         4'h5, 4'hF:                      n = 2'd1;
         4'h2, 4'h6, 4'hC, 4'hD:          n = 2'd2;
         default:                         n = 2'd3;
      endcase
      return n;
   endfunction

endpackage

[hdl/umepc_codec.sv]
`timescale 1ns / 1ps

module umepc_codec (
   input  umepc_pkg::req_item_type item,
   input  logic [3:0]              cable,
   output umepc_pkg::rsp_item_type result
);
   import umepc_pkg::*;

   logic       status_ok;
   logic [3:0] cin;
   logic [1:0] expected;
   logic       len_ok;
   logic [1:0] dec_len;

   // status byte classification
   always_comb begin
      status_ok = 1'b0;
      cin       = 4'h0;
      expected  = 2'd0;
      if (item.first_byte < STATUS_MIN) begin
         status_ok = 1'b0;
      end else if (item.first_byte >= REALTIME_MIN) begin
         status_ok = 1'b1;
         cin       = CIN_SINGLE;
         expected  = 2'd1;
      end else if (item.first_byte[7:4] != SYSTEM_NIBBLE) begin
         status_ok = 1'b1;
         cin       = item.first_byte[7:4];
         expected  = (item.first_byte[7:4] == PROGRAM_NIBBLE ||
                      item.first_byte[7:4] == PRESSURE_NIBBLE) ? 2'd2 : 2'd3;
      end else begin
         case (item.first_byte)
            STATUS_MTC: begin
               status_ok = 1'b1; cin = CIN_TWO_BYTE;   expected = 2'd2;
            end
            STATUS_SPP: begin
               status_ok = 1'b1; cin = CIN_THREE_BYTE; expected = 2'd3;
            end
            STATUS_SONG: begin
               status_ok = 1'b1; cin = CIN_TWO_BYTE;   expected = 2'd2;
            end
            STATUS_TUNE: begin
               status_ok = 1'b1; cin = CIN_ONE_SYS;    expected = 2'd1;
            end
            default: begin
               status_ok = 1'b0;
            end
         endcase
      end
   end

   assign len_ok  = (item.message_length != 3'd0) && (item.message_length <= MAX_LENGTH);
   assign dec_len = cin_length(item.header_byte[3:0]);

   always_comb begin
      result = '0;
      case (item.operation)
         OP_ENCODE: begin
            if (len_ok && status_ok && (item.message_length >= {1'b0, expected})) begin
               result.accepted  = 1'b1;
               result.out_byte0 = {cable, cin};
               result.out_byte1 = item.first_byte;
               result.out_byte2 = (item.message_length > 3'd1) ? item.second_byte : 8'h00;
               result.out_byte3 = (item.message_length > 3'd2) ? item.third_byte : 8'h00;
            end
         end
         OP_DECODE: begin
            if (dec_len != 2'd0) begin
               result.accepted   = 1'b1;
               result.out_byte0  = item.first_byte;
               result.out_byte1  = item.second_byte;
               result.out_byte2  = item.third_byte;
               result.out_length = dec_len;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

[hdl/usb_midi_event_packet_codec.sv]
`timescale 1ns / 1ps
// Accepted req items pass the input register, then the result register that drives rsp_valid.
// One item per cycle while rsp_ready is high; the input register refills while a result waits.
// Each stage advances when its successor is empty or being drained.
// Reset (synchronous, active high) empties both stages and clears the cable number to 0.

module usb_midi_event_packet_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_header_byte,
   input  logic [7:0] req_first_byte,
   input  logic [7:0] req_second_byte,
   input  logic [7:0] req_third_byte,
   input  logic [2:0] req_message_length,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [1:0] rsp_out_length,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);
   import umepc_pkg::*;

   logic [3:0]   cable_ff, cable_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type result;
   logic         out_free;
   logic         req_take;

   umepc_codec u_codec (
      .item   (in_item_ff),
      .cable  (cable_ff),
      .result (result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cable_in = csr_write_enable ? csr_write_data : cable_ff;

      in_valid_in = req_ready ? req_valid : in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_item_in.operation      = op_type'(req_operation);
         in_item_in.header_byte    = req_header_byte;
         in_item_in.first_byte     = req_first_byte;
         in_item_in.second_byte    = req_second_byte;
         in_item_in.third_byte     = req_third_byte;
         in_item_in.message_length = req_message_length;
      end

      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      out_item_in  = (out_free && in_valid_ff) ? result : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cable_ff     <= 4'h0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cable_ff     <= cable_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_accepted   = out_item_ff.accepted;
   assign rsp_out_byte0  = out_item_ff.out_byte0;
   assign rsp_out_byte1  = out_item_ff.out_byte1;
   assign rsp_out_byte2  = out_item_ff.out_byte2;
   assign rsp_out_byte3  = out_item_ff.out_byte3;
   assign rsp_out_length = out_item_ff.out_length;

   // refused or dropped items carry no bytes
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_out_byte0 == 8'h00 && rsp_out_byte1 == 8'h00 &&
         rsp_out_byte2 == 8'h00 && rsp_out_byte3 == 8'h00 && rsp_out_length == 2'd0))
      else $error("refused item has nonzero payload");

   // decode results never fill byte 3, encode results never set a length
   a_byte3_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_byte3 != 8'h00) |-> (rsp_out_length == 2'd0))
      else $error("byte 3 and length both set");

   a_len_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_length != 2'd0) |-> rsp_accepted)
      else $error("length set on refused item");

   // a held item moves to the result register whenever it is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> rsp_valid)
      else $error("item lost between stages");

endmodule
